// ----- sv/gnfss_pkg.sv -----
// Shared types, constants and constant-divider helpers for the gain noise filter block.
package gnfss_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_NF2_ADJUST     = 3'd0,
    REG_PERSIST_LIMIT  = 3'd1,
    REG_SET1_AGAIN_MIN = 3'd2,
    REG_SET2_AGAIN_MIN = 3'd3,
    REG_SET2_DGAIN_MIN = 3'd4
  } reg_idx_t;

  // Colour matrix request codes
  typedef enum logic [1:0] {
    REQ_NONE    = 2'd0,
    REQ_REFRESH = 2'd1,
    REQ_SWITCH  = 2'd2
  } req_t;

  // Tuning set codes, 3-bit two's complement
  localparam logic signed [2:0] SET_NONE = 3'sb111;
  localparam logic signed [2:0] SET_0    = 3'sd0;
  localparam logic signed [2:0] SET_1    = 3'sd1;
  localparam logic signed [2:0] SET_2    = 3'sd2;

  localparam int unsigned OUT_THRESH = 8;

  // Gain caps and filter level constants
  localparam logic [15:0] AGAIN_CAP  = 16'd40000;
  localparam logic [15:0] AGAIN_KNEE = 16'd10000;
  localparam logic [15:0] DGAIN_CAP  = 16'd1536;
  localparam logic [10:0] DGAIN_UNIT = 11'd1000;
  localparam logic signed [11:0] LEVEL_BASE = 12'sd20;
  localparam logic signed [11:0] LEVEL_MAX  = 12'sd200;
  localparam logic signed [11:0] LEVEL_MIN  = 12'sd16;

  // Reset values of the configuration registers
  localparam logic signed [8:0] NF2_ADJUST_RST     = 9'sd0;
  localparam logic [7:0]        PERSIST_LIMIT_RST  = 8'd100;
  localparam logic [15:0]       SET1_AGAIN_MIN_RST = 16'd20000;
  localparam logic [15:0]       SET2_AGAIN_MIN_RST = 16'd40000;
  localparam logic [15:0]       SET2_DGAIN_MIN_RST = 16'd1280;

  // Reciprocals: x/300 = (x>>2)*6991 >> 19 for x <= 30000,
  // y/10 = y*820 >> 13 for y <= 1000, y/10 = y*1639 >> 14 for y <= 1400.
  localparam logic [12:0] RECIP_75    = 13'd6991;
  localparam logic [9:0]  RECIP_10_13 = 10'd820;
  localparam logic [10:0] RECIP_10_14 = 11'd1639;

  function automatic logic [6:0] div300(input logic [14:0] x);
    logic [25:0] p;
    p = 26'(x[14:2]) * 26'(RECIP_75);
    return p[25:19];
  endfunction

  function automatic logic [6:0] div10_small(input logic [9:0] y);
    logic [19:0] p;
    p = 20'(y) * 20'(RECIP_10_13);
    return p[19:13];
  endfunction

endpackage

// ----- sv/gain_noise_filter_and_set_select.sv -----
// Gain noise filter level, threshold expansion and tuning set selection.
// Pipeline registers: input reg, level reg, result reg.
// Throughput: one item per cycle; input is stalled only when all three stages are
// full and the result is stalled.
// Reset (rst, synchronous): pipeline empty, config at defaults, last level all
// ones, both sets at -1, persist count zero.
module gain_noise_filter_and_set_select
  import gnfss_pkg::*;
#(
  parameter int unsigned THRESH_ENTRIES = 8
) (
  input  logic               clk,
  input  logic               rst,
  // config write port
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [15:0]        wr_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        analog_gain,
  input  logic [15:0]        digital_gain,
  input  logic signed [7:0]  noise_level,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         thresh_0,
  output logic [7:0]         thresh_1,
  output logic [7:0]         thresh_2,
  output logic [8:0]         thresh_3,
  output logic [8:0]         thresh_4,
  output logic [8:0]         thresh_5,
  output logic [8:0]         thresh_6,
  output logic [8:0]         thresh_7,
  output logic               level_changed,
  output logic signed [2:0]  steady_set,
  output logic [1:0]         matrix_request
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [8:0] nf2_adjust;
  logic [7:0]        persist_limit;
  logic [15:0]       set1_again_min;
  logic [15:0]       set2_again_min;
  logic [15:0]       set2_dgain_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      nf2_adjust     <= NF2_ADJUST_RST;
      persist_limit  <= PERSIST_LIMIT_RST;
      set1_again_min <= SET1_AGAIN_MIN_RST;
      set2_again_min <= SET2_AGAIN_MIN_RST;
      set2_dgain_min <= SET2_DGAIN_MIN_RST;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_NF2_ADJUST:     nf2_adjust     <= $signed(wr_data[8:0]);
        REG_PERSIST_LIMIT:  persist_limit  <= wr_data[7:0];
        REG_SET1_AGAIN_MIN: set1_again_min <= wr_data;
        REG_SET2_AGAIN_MIN: set2_again_min <= wr_data;
        REG_SET2_DGAIN_MIN: set2_dgain_min <= wr_data;
        default: ;  // writes beyond the map are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: each stage loads when empty or when the next one
  // loads, so a held result never blocks the stages behind it until all fill.
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic s2_valid;
  logic adv_out;
  logic adv2;
  logic adv1;

  assign adv_out  = !out_valid || !out_stall;
  assign adv2     = !s2_valid || adv_out;
  assign adv1     = !s1_valid || adv2;
  assign in_stall = !adv1;

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic [15:0]       s1_again;
  logic [15:0]       s1_dgain;
  logic signed [7:0] s1_noise;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && adv1) begin
      s1_again <= analog_gain;
      s1_dgain <= digital_gain;
      s1_noise <= noise_level;
    end
  end

  // ---------------------------------------------------------------------------
  // Level and candidate set from the input register
  // ---------------------------------------------------------------------------
  logic [15:0]        ag_cap;
  logic [10:0]        dg_cap;
  logic [14:0]        ag_excess;
  logic               dg_below;
  logic [9:0]         dg_mag;
  logic [6:0]         q_again;
  logic [6:0]         q_dgain;
  logic signed [11:0] q_dgain_s;
  logic signed [11:0] level_sum;
  logic [7:0]         level_calc;
  logic signed [2:0]  cand_calc;

  always_comb begin
    ag_cap    = (s1_again > AGAIN_CAP) ? AGAIN_CAP : s1_again;
    dg_cap    = (s1_dgain > DGAIN_CAP) ? DGAIN_CAP[10:0] : s1_dgain[10:0];
    ag_excess = 15'(ag_cap - AGAIN_KNEE);
    dg_below  = dg_cap < DGAIN_UNIT;
    // truncation toward zero: divide the magnitude, then restore the sign
    dg_mag    = dg_below ? 10'(DGAIN_UNIT - dg_cap) : 10'(dg_cap - DGAIN_UNIT);
    q_again   = div300(ag_excess);
    q_dgain   = div10_small(dg_mag);
    q_dgain_s = dg_below ? -$signed({5'b0, q_dgain}) : $signed({5'b0, q_dgain});

    if (ag_cap < AGAIN_KNEE) begin
      level_sum = LEVEL_BASE;
    end else begin
      level_sum = LEVEL_BASE + $signed({5'b0, q_again}) + q_dgain_s;
    end
    level_sum = level_sum + 12'(nf2_adjust) + 12'(s1_noise);

    if (level_sum > LEVEL_MAX) begin
      level_calc = LEVEL_MAX[7:0];
    end else if (level_sum < LEVEL_MIN) begin
      level_calc = LEVEL_MIN[7:0];
    end else begin
      level_calc = level_sum[7:0];
    end

    if (s1_again >= set2_again_min && s1_dgain >= set2_dgain_min) begin
      cand_calc = SET_2;
    end else if (s1_again >= set1_again_min) begin
      cand_calc = SET_1;
    end else begin
      cand_calc = SET_0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: level register
  // ---------------------------------------------------------------------------
  logic [7:0]        s2_level;
  logic signed [2:0] s2_cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && adv2) begin
      s2_level <= level_calc;
      s2_cand  <= cand_calc;
    end
  end

  // ---------------------------------------------------------------------------
  // Threshold expansion: entry i = level + floor(i*level/10) below THRESH_ENTRIES,
  // else zero; one constant multiply per entry, reciprocal folded into the constant.
  // ---------------------------------------------------------------------------
  logic [8:0] thr [OUT_THRESH];

  for (genvar i = 0; i < OUT_THRESH; i++) begin : g_thr
    localparam logic [13:0] ThrConst = 14'(i * RECIP_10_14);
    logic [21:0] prod;
    assign prod   = 22'(s2_level) * 22'(ThrConst);
    assign thr[i] = (i < THRESH_ENTRIES) ? 9'(s2_level) + 9'(prod[21:14]) : 9'd0;
  end

  // ---------------------------------------------------------------------------
  // Frame-to-frame state: level history and set persistence
  // ---------------------------------------------------------------------------
  logic [8:0]        last_level;
  logic signed [2:0] settled_set;
  logic signed [2:0] pending_set;
  logic [7:0]        persist_count;

  logic signed [2:0] settled_set_next;
  logic signed [2:0] pending_set_next;
  logic [7:0]        persist_count_next;
  req_t              req_next;

  always_comb begin
    settled_set_next   = settled_set;
    pending_set_next   = pending_set;
    persist_count_next = persist_count;
    req_next           = REQ_NONE;
    if (settled_set == s2_cand) begin
      req_next           = REQ_REFRESH;
      pending_set_next   = SET_NONE;
      persist_count_next = 8'd0;
    end else if (pending_set == s2_cand && persist_count >= persist_limit) begin
      settled_set_next   = s2_cand;
      pending_set_next   = SET_NONE;
      persist_count_next = 8'd0;
      req_next           = REQ_SWITCH;
    end else if (pending_set == s2_cand) begin
      persist_count_next = persist_count + 8'd1;
    end else begin
      pending_set_next   = s2_cand;
      persist_count_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      last_level    <= '1;
      settled_set   <= SET_NONE;
      pending_set   <= SET_NONE;
      persist_count <= 8'd0;
    end else begin
      if (adv_out) begin
        out_valid <= s2_valid;
      end
      if (s2_valid && adv_out) begin
        last_level    <= {1'b0, s2_level};
        settled_set   <= settled_set_next;
        pending_set   <= pending_set_next;
        persist_count <= persist_count_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s2_valid && adv_out) begin
      thresh_0       <= thr[0][7:0];
      thresh_1       <= thr[1][7:0];
      thresh_2       <= thr[2][7:0];
      thresh_3       <= thr[3];
      thresh_4       <= thr[4];
      thresh_5       <= thr[5];
      thresh_6       <= thr[6];
      thresh_7       <= thr[7];
      level_changed  <= ({1'b0, s2_level} != last_level);
      steady_set     <= settled_set_next;
      matrix_request <= 2'(req_next);
    end
  end

endmodule
